// File: rtl/nirt_pkg.sv
// shared types, codes and helpers for the nec ir transmitter
package nirt_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CARRIER_HALF = 3'd0;
    localparam logic [2:0] REG_LEADER_MARK  = 3'd1;
    localparam logic [2:0] REG_BIT_MARK     = 3'd2;
    localparam logic [2:0] REG_LEADER_SPACE = 3'd3;
    localparam logic [2:0] REG_REPEAT_SPACE = 3'd4;
    localparam logic [2:0] REG_ZERO_SPACE   = 3'd5;
    localparam logic [2:0] REG_ONE_SPACE    = 3'd6;
    localparam logic [2:0] REG_FRAME_GAP    = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
    localparam logic [9:0]  RST_LEADER_MARK  = 10'd346;
    localparam logic [9:0]  RST_BIT_MARK     = 10'd21;
    localparam logic [15:0] RST_LEADER_SPACE = 16'd4500;
    localparam logic [15:0] RST_REPEAT_SPACE = 16'd2250;
    localparam logic [15:0] RST_ZERO_SPACE   = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE    = 16'd1690;
    localparam logic [15:0] RST_FRAME_GAP    = 16'd45000;

    // waveform phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_LEAD_MARK  = 4'd1;
    localparam logic [3:0] PH_LEAD_SPACE = 4'd2;
    localparam logic [3:0] PH_BIT_MARK   = 4'd3;
    localparam logic [3:0] PH_BIT_SPACE  = 4'd4;
    localparam logic [3:0] PH_STOP_MARK  = 4'd5;
    localparam logic [3:0] PH_GAP        = 4'd6;
    localparam logic [3:0] PH_REP_MARK   = 4'd7;
    localparam logic [3:0] PH_REP_SPACE  = 4'd8;

    localparam logic [5:0] FRAME_BITS = 6'd32;

    typedef struct packed {
        logic [0:0] mode;
        logic [7:0] address;
        logic [7:0] command;
        logic [7:0] repeat_count;
    } in_t;

    typedef struct packed {
        logic [0:0] pin_level;
        logic [0:0] busy_res;
        logic [0:0] rejected;
    } out_t;

    // classified request held in the queue between front and back
    typedef struct packed {
        logic        is_start;
        logic [31:0] frame_bits;
        logic [7:0]  repeat_count;
    } req_t;

    typedef struct packed {
        logic [7:0]  carrier_half;
        logic [9:0]  leader_mark;
        logic [9:0]  bit_mark;
        logic [15:0] leader_space;
        logic [15:0] repeat_space;
        logic [15:0] zero_space;
        logic [15:0] one_space;
        logic [15:0] frame_gap;
    } cfg_t;

    // a zero register value counts as one
    function automatic logic [7:0] nz8(input logic [7:0] v);
        nz8 = (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [9:0] nz10(input logic [9:0] v);
        nz10 = (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [15:0] nz16(input logic [15:0] v);
        nz16 = (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// File: rtl/nec_ir_transmitter_top.sv
// top level of the nec ir transmitter: config registers, front end, back end
// a request waits in a queue entry, then its result is held in the result register until taken
// throughput: one request per cycle, ticks and start requests alike, while neither channel stalls
// the two-entry queue and the result register keep input and output stalls apart
// reset: config registers return to defaults, sequencer idle, queue and result empty
module nec_ir_transmitter_top
(
    input  logic           clk,
    input  logic           rst_n,
    // request channel
    input  logic           in_valid,
    output logic           in_stall,
    input  nirt_pkg::in_t  in_data,
    // result channel
    output logic           out_valid,
    input  logic           out_stall,
    output nirt_pkg::out_t out_data,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    nirt_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           cfg_write;
    logic           q_valid;
    logic           q_pop;
    nirt_pkg::req_t q_head;

    // one 32-bit word per register
    assign reg_index = paddr[4:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // readback, zero extended
    always_comb
    begin
        case (reg_index)
            nirt_pkg::REG_CARRIER_HALF: prdata = {24'd0, cfg_reg.carrier_half};
            nirt_pkg::REG_LEADER_MARK:  prdata = {22'd0, cfg_reg.leader_mark};
            nirt_pkg::REG_BIT_MARK:     prdata = {22'd0, cfg_reg.bit_mark};
            nirt_pkg::REG_LEADER_SPACE: prdata = {16'd0, cfg_reg.leader_space};
            nirt_pkg::REG_REPEAT_SPACE: prdata = {16'd0, cfg_reg.repeat_space};
            nirt_pkg::REG_ZERO_SPACE:   prdata = {16'd0, cfg_reg.zero_space};
            nirt_pkg::REG_ONE_SPACE:    prdata = {16'd0, cfg_reg.one_space};
            nirt_pkg::REG_FRAME_GAP:    prdata = {16'd0, cfg_reg.frame_gap};
            default:                    prdata = 32'd0;
        endcase
    end

    // config writes take effect at once, the next popped request sees them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_half <= nirt_pkg::RST_CARRIER_HALF;
            cfg_reg.leader_mark  <= nirt_pkg::RST_LEADER_MARK;
            cfg_reg.bit_mark     <= nirt_pkg::RST_BIT_MARK;
            cfg_reg.leader_space <= nirt_pkg::RST_LEADER_SPACE;
            cfg_reg.repeat_space <= nirt_pkg::RST_REPEAT_SPACE;
            cfg_reg.zero_space   <= nirt_pkg::RST_ZERO_SPACE;
            cfg_reg.one_space    <= nirt_pkg::RST_ONE_SPACE;
            cfg_reg.frame_gap    <= nirt_pkg::RST_FRAME_GAP;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                nirt_pkg::REG_CARRIER_HALF: cfg_reg.carrier_half <= pwdata[7:0];
                nirt_pkg::REG_LEADER_MARK:  cfg_reg.leader_mark  <= pwdata[9:0];
                nirt_pkg::REG_BIT_MARK:     cfg_reg.bit_mark     <= pwdata[9:0];
                nirt_pkg::REG_LEADER_SPACE: cfg_reg.leader_space <= pwdata[15:0];
                nirt_pkg::REG_REPEAT_SPACE: cfg_reg.repeat_space <= pwdata[15:0];
                nirt_pkg::REG_ZERO_SPACE:   cfg_reg.zero_space   <= pwdata[15:0];
                nirt_pkg::REG_ONE_SPACE:    cfg_reg.one_space    <= pwdata[15:0];
                nirt_pkg::REG_FRAME_GAP:    cfg_reg.frame_gap    <= pwdata[15:0];
                default:                    cfg_reg.frame_gap    <= cfg_reg.frame_gap;
            endcase
        end
    end

    // front: takes each request, builds the 32-bit frame word, queues it
    nirt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    // back: one microsecond of waveform per tick, result register on the output
    nirt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: rtl/nirt_front.sv
// front end: accepts requests, builds the frame word, two-entry queue
module nirt_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nirt_pkg::in_t  in_data,
    output logic           q_valid,
    input  logic           q_pop,
    output nirt_pkg::req_t q_head
);

    nirt_pkg::req_t queue_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    nirt_pkg::req_t entry;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = queue_reg[rd_ptr_reg];

    // address, inverted address, command, inverted command, lsb first
    always_comb
    begin
        entry.is_start     = in_data.mode[0];
        entry.frame_bits   = {~in_data.command, in_data.command,
                              ~in_data.address, in_data.address};
        entry.repeat_count = in_data.repeat_count;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: rtl/nirt_back.sv
// back end: waveform sequencer and result register
module nirt_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  nirt_pkg::cfg_t cfg,
    input  logic           q_valid,
    output logic           q_pop,
    input  nirt_pkg::req_t q_head,
    output logic           out_valid,
    input  logic           out_stall,
    output nirt_pkg::out_t out_data
);

    logic [3:0]     phase_reg, phase_next;
    logic [31:0]    frame_bits_reg, frame_bits_next;
    logic [5:0]     bits_left_reg, bits_left_next;
    logic [7:0]     repeats_left_reg, repeats_left_next;
    logic [15:0]    space_timer_reg, space_timer_next;
    logic [9:0]     periods_left_reg, periods_left_next;
    logic [7:0]     half_timer_reg, half_timer_next;
    logic           level_reg, level_next;
    logic           out_valid_reg;
    nirt_pkg::out_t out_data_reg, out_data_next;

    logic [7:0]  half_dec;
    logic [9:0]  periods_dec;
    logic [15:0] space_dec;
    logic [5:0]  bits_dec;
    logic        in_mark;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign half_dec    = half_timer_reg - 8'd1;
    assign periods_dec = periods_left_reg - 10'd1;
    assign space_dec   = space_timer_reg - 16'd1;
    assign bits_dec    = bits_left_reg - 6'd1;
    assign in_mark     = (phase_reg == nirt_pkg::PH_LEAD_MARK) ||
                         (phase_reg == nirt_pkg::PH_BIT_MARK)  ||
                         (phase_reg == nirt_pkg::PH_STOP_MARK) ||
                         (phase_reg == nirt_pkg::PH_REP_MARK);

    always_comb
    begin
        phase_next        = phase_reg;
        frame_bits_next   = frame_bits_reg;
        bits_left_next    = bits_left_reg;
        repeats_left_next = repeats_left_reg;
        space_timer_next  = space_timer_reg;
        periods_left_next = periods_left_reg;
        half_timer_next   = half_timer_reg;
        level_next        = level_reg;
        out_data_next     = '0;

        if (q_head.is_start)
        begin
            out_data_next.busy_res = 1'b1;
            if (phase_reg != nirt_pkg::PH_IDLE)
            begin
                out_data_next.rejected = 1'b1;
            end
            else
            begin
                frame_bits_next   = q_head.frame_bits;
                bits_left_next    = nirt_pkg::FRAME_BITS;
                repeats_left_next = q_head.repeat_count;
                phase_next        = nirt_pkg::PH_LEAD_MARK;
                periods_left_next = nirt_pkg::nz10(cfg.leader_mark);
                half_timer_next   = nirt_pkg::nz8(cfg.carrier_half);
                level_next        = 1'b1;
            end
        end
        else if (phase_reg != nirt_pkg::PH_IDLE)
        begin
            out_data_next.busy_res = 1'b1;
            if (in_mark)
            begin
                out_data_next.pin_level = level_reg;
                half_timer_next = half_dec;
                if (half_dec == 8'd0)
                begin
                    if (level_reg)
                    begin
                        // high half done, go low
                        level_next      = 1'b0;
                        half_timer_next = nirt_pkg::nz8(cfg.carrier_half);
                    end
                    else
                    begin
                        periods_left_next = periods_dec;
                        if (periods_dec == 10'd0)
                        begin
                            // mark finished, pick the following space
                            level_next = 1'b0;
                            case (phase_reg)
                                nirt_pkg::PH_LEAD_MARK:
                                begin
                                    phase_next       = nirt_pkg::PH_LEAD_SPACE;
                                    space_timer_next = nirt_pkg::nz16(cfg.leader_space);
                                end
                                nirt_pkg::PH_BIT_MARK:
                                begin
                                    phase_next       = nirt_pkg::PH_BIT_SPACE;
                                    space_timer_next = frame_bits_reg[0] ?
                                                       nirt_pkg::nz16(cfg.one_space) :
                                                       nirt_pkg::nz16(cfg.zero_space);
                                end
                                nirt_pkg::PH_REP_MARK:
                                begin
                                    phase_next       = nirt_pkg::PH_REP_SPACE;
                                    space_timer_next = nirt_pkg::nz16(cfg.repeat_space);
                                end
                                default:
                                begin
                                    // stop mark: next repeat or done
                                    if (repeats_left_reg != 8'd0)
                                    begin
                                        repeats_left_next = repeats_left_reg - 8'd1;
                                        phase_next        = nirt_pkg::PH_GAP;
                                        space_timer_next  = nirt_pkg::nz16(cfg.frame_gap);
                                    end
                                    else
                                    begin
                                        phase_next = nirt_pkg::PH_IDLE;
                                    end
                                end
                            endcase
                        end
                        else
                        begin
                            level_next      = 1'b1;
                            half_timer_next = nirt_pkg::nz8(cfg.carrier_half);
                        end
                    end
                end
            end
            else
            begin
                space_timer_next = space_dec;
                if (space_dec == 16'd0)
                begin
                    // space finished, start the following mark
                    level_next      = 1'b1;
                    half_timer_next = nirt_pkg::nz8(cfg.carrier_half);
                    case (phase_reg)
                        nirt_pkg::PH_LEAD_SPACE:
                        begin
                            phase_next        = nirt_pkg::PH_BIT_MARK;
                            periods_left_next = nirt_pkg::nz10(cfg.bit_mark);
                        end
                        nirt_pkg::PH_BIT_SPACE:
                        begin
                            frame_bits_next   = {1'b0, frame_bits_reg[31:1]};
                            bits_left_next    = bits_dec;
                            periods_left_next = nirt_pkg::nz10(cfg.bit_mark);
                            phase_next        = (bits_dec == 6'd0) ?
                                                nirt_pkg::PH_STOP_MARK :
                                                nirt_pkg::PH_BIT_MARK;
                        end
                        nirt_pkg::PH_GAP:
                        begin
                            phase_next        = nirt_pkg::PH_REP_MARK;
                            periods_left_next = nirt_pkg::nz10(cfg.leader_mark);
                        end
                        default:
                        begin
                            phase_next        = nirt_pkg::PH_STOP_MARK;
                            periods_left_next = nirt_pkg::nz10(cfg.bit_mark);
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= nirt_pkg::PH_IDLE;
            frame_bits_reg   <= '0;
            bits_left_reg    <= '0;
            repeats_left_reg <= '0;
            space_timer_reg  <= '0;
            periods_left_reg <= '0;
            half_timer_reg   <= '0;
            level_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg        <= phase_next;
                frame_bits_reg   <= frame_bits_next;
                bits_left_reg    <= bits_left_next;
                repeats_left_reg <= repeats_left_next;
                space_timer_reg  <= space_timer_next;
                periods_left_reg <= periods_left_next;
                half_timer_reg   <= half_timer_next;
                level_reg        <= level_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: dv/nec_ir_transmitter_top_tb.sv
// self-checking testbench for the nec ir transmitter top level
module nec_ir_transmitter_top_tb;

    // generous ceiling on the run length, counted in clock cycles
    localparam int CYCLE_LIMIT = 200_000;
    localparam int REPORT_MAX  = 10;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    nirt_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    nirt_pkg::out_t out_data;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [4:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    nec_ir_transmitter_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // idle percentages for the request sender and the result receiver
    int send_idle_pct;
    int recv_idle_pct;

    // bookkeeping
    int n_errors;
    int n_reg_errors;
    int n_requests;
    int n_results;
    int n_starts;
    int n_rejects;
    int n_reg_writes;
    int cycle_count;

    // expected results, oldest first
    nirt_pkg::out_t expected_levels[$];

    // mirror of the timing registers
    nirt_pkg::cfg_t timing;

    // private copy of the waveform sequencer
    logic [3:0]  wave_phase;
    logic [31:0] wave_bits;
    logic [5:0]  wave_bits_left;
    logic [7:0]  wave_repeats;
    logic [15:0] wave_space;
    logic [9:0]  wave_periods;
    logic [7:0]  wave_half;
    logic        wave_level;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run ceiling, counted in clock cycles
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_levels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge only
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result mismatch log: only the first few get printed in full
    function automatic void note_mismatch(input string msg);
        if (n_errors + n_reg_errors < REPORT_MAX)
            $display("mismatch: %s", msg);
        n_errors++;
    endfunction

    // register readback mismatch log
    function automatic void note_reg_mismatch(input string msg);
        if (n_errors + n_reg_errors < REPORT_MAX)
            $display("mismatch: %s", msg);
        n_reg_errors++;
    endfunction

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        nirt_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_levels.size() == 0)
                note_mismatch($sformatf("result with nothing pending: pin %0b busy %0b rej %0b",
                                        out_data.pin_level, out_data.busy_res,
                                        out_data.rejected));
            else
            begin
                want = expected_levels.pop_front();
                if (out_data.pin_level !== want.pin_level ||
                    out_data.busy_res !== want.busy_res ||
                    out_data.rejected !== want.rejected)
                    note_mismatch($sformatf(
                        "result %0d: exp pin %0b busy %0b rej %0b, got pin %0b busy %0b rej %0b",
                        n_results, want.pin_level, want.busy_res, want.rejected,
                        out_data.pin_level, out_data.busy_res, out_data.rejected));
            end
        end
    end

    // ------------------------------------------------------------------
    // waveform predictor
    // ------------------------------------------------------------------

    // carrier half period, a zero register counts as one
    function automatic logic [7:0] half_reload();
        return (timing.carrier_half == 8'd0) ? 8'd1 : timing.carrier_half;
    endfunction

    function automatic void enter_mark(input logic [3:0] ph, input logic [9:0] periods);
        wave_phase   = ph;
        wave_periods = (periods == 10'd0) ? 10'd1 : periods;
        wave_half    = half_reload();
        wave_level   = 1'b1;
    endfunction

    function automatic void enter_space(input logic [3:0] ph, input logic [15:0] us);
        wave_phase = ph;
        wave_space = (us == 16'd0) ? 16'd1 : us;
        wave_level = 1'b0;
    endfunction

    // advance the sequencer copy by one request and return its expected result
    function automatic nirt_pkg::out_t nec_waveform_step(input nirt_pkg::in_t req);
        nirt_pkg::out_t res;
        res = '0;
        if (req.mode == 1'b1)
        begin
            if (wave_phase != nirt_pkg::PH_IDLE)
            begin
                // busy: the frame in flight is left alone
                res.rejected = 1'b1;
                n_rejects++;
            end
            else
            begin
                wave_bits      = {~req.command, req.command, ~req.address, req.address};
                wave_bits_left = nirt_pkg::FRAME_BITS;
                wave_repeats   = req.repeat_count;
                enter_mark(nirt_pkg::PH_LEAD_MARK, timing.leader_mark);
                n_starts++;
            end
            res.busy_res = 1'b1;
        end
        else if (wave_phase != nirt_pkg::PH_IDLE)
        begin
            res.busy_res = 1'b1;
            if (wave_phase == nirt_pkg::PH_LEAD_MARK || wave_phase == nirt_pkg::PH_BIT_MARK ||
                wave_phase == nirt_pkg::PH_STOP_MARK || wave_phase == nirt_pkg::PH_REP_MARK)
            begin
                res.pin_level = wave_level;
                wave_half = wave_half - 8'd1;
                if (wave_half == 8'd0)
                begin
                    if (wave_level)
                    begin
                        wave_level = 1'b0;
                        wave_half  = half_reload();
                    end
                    else
                    begin
                        wave_periods = wave_periods - 10'd1;
                        if (wave_periods != 10'd0)
                        begin
                            wave_level = 1'b1;
                            wave_half  = half_reload();
                        end
                        else
                        begin
                            case (wave_phase)
                                nirt_pkg::PH_LEAD_MARK:
                                    enter_space(nirt_pkg::PH_LEAD_SPACE, timing.leader_space);
                                nirt_pkg::PH_BIT_MARK:
                                    enter_space(nirt_pkg::PH_BIT_SPACE, wave_bits[0] ?
                                                timing.one_space : timing.zero_space);
                                nirt_pkg::PH_REP_MARK:
                                    enter_space(nirt_pkg::PH_REP_SPACE, timing.repeat_space);
                                default:
                                begin
                                    // end of a stop mark
                                    if (wave_repeats != 8'd0)
                                    begin
                                        wave_repeats = wave_repeats - 8'd1;
                                        enter_space(nirt_pkg::PH_GAP, timing.frame_gap);
                                    end
                                    else
                                    begin
                                        wave_phase = nirt_pkg::PH_IDLE;
                                        wave_level = 1'b0;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            else
            begin
                wave_space = wave_space - 16'd1;
                if (wave_space == 16'd0)
                begin
                    case (wave_phase)
                        nirt_pkg::PH_LEAD_SPACE:
                            enter_mark(nirt_pkg::PH_BIT_MARK, timing.bit_mark);
                        nirt_pkg::PH_BIT_SPACE:
                        begin
                            wave_bits      = wave_bits >> 1;
                            wave_bits_left = wave_bits_left - 6'd1;
                            enter_mark((wave_bits_left == 6'd0) ? nirt_pkg::PH_STOP_MARK :
                                       nirt_pkg::PH_BIT_MARK, timing.bit_mark);
                        end
                        nirt_pkg::PH_GAP:
                            enter_mark(nirt_pkg::PH_REP_MARK, timing.leader_mark);
                        default:
                            enter_mark(nirt_pkg::PH_STOP_MARK, timing.bit_mark);
                    endcase
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request and register helpers
    // ------------------------------------------------------------------

    function automatic nirt_pkg::in_t tick_request();
        nirt_pkg::in_t req;
        req              = '0;
        req.address      = 8'($urandom);
        req.command      = 8'($urandom);
        req.repeat_count = 8'($urandom);
        return req;
    endfunction

    function automatic nirt_pkg::in_t start_request(input logic [7:0] addr,
                                                    input logic [7:0] cmd,
                                                    input logic [7:0] reps);
        nirt_pkg::in_t req;
        req.mode         = 1'b1;
        req.address      = addr;
        req.command      = cmd;
        req.repeat_count = reps;
        return req;
    endfunction

    // present one request from a falling edge and hold it until accepted
    // valid is left high so a back-to-back request needs no second assignment
    task automatic send_request(input nirt_pkg::in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_levels.push_back(nec_waveform_step(req));
        n_requests++;
        @(negedge clk);
    endtask

    // stop sending and wait until every expected result is back, plus pipeline slack
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // tick through the current transmission, with an optional rate of rejected starts
    task automatic run_to_idle(input int reject_pct);
        while (wave_phase != nirt_pkg::PH_IDLE)
        begin
            if ($urandom_range(99) < reject_pct)
                send_request(start_request(8'($urandom), 8'($urandom), 8'($urandom)));
            else
                send_request(tick_request());
        end
    endtask

    function automatic logic [31:0] reg_mirror_value(input logic [2:0] idx);
        case (idx)
            nirt_pkg::REG_CARRIER_HALF: return {24'd0, timing.carrier_half};
            nirt_pkg::REG_LEADER_MARK:  return {22'd0, timing.leader_mark};
            nirt_pkg::REG_BIT_MARK:     return {22'd0, timing.bit_mark};
            nirt_pkg::REG_LEADER_SPACE: return {16'd0, timing.leader_space};
            nirt_pkg::REG_REPEAT_SPACE: return {16'd0, timing.repeat_space};
            nirt_pkg::REG_ZERO_SPACE:   return {16'd0, timing.zero_space};
            nirt_pkg::REG_ONE_SPACE:    return {16'd0, timing.one_space};
            default:                    return {16'd0, timing.frame_gap};
        endcase
    endfunction

    task automatic reg_read_check(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== reg_mirror_value(idx))
            note_reg_mismatch($sformatf("register %0d read back: exp 0x%0h got 0x%0h",
                                        idx, reg_mirror_value(idx), prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // write one register, update the mirror, then read it back
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            nirt_pkg::REG_CARRIER_HALF: timing.carrier_half = value[7:0];
            nirt_pkg::REG_LEADER_MARK:  timing.leader_mark  = value[9:0];
            nirt_pkg::REG_BIT_MARK:     timing.bit_mark     = value[9:0];
            nirt_pkg::REG_LEADER_SPACE: timing.leader_space = value[15:0];
            nirt_pkg::REG_REPEAT_SPACE: timing.repeat_space = value[15:0];
            nirt_pkg::REG_ZERO_SPACE:   timing.zero_space   = value[15:0];
            nirt_pkg::REG_ONE_SPACE:    timing.one_space    = value[15:0];
            default:                    timing.frame_gap    = value[15:0];
        endcase
        n_reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        reg_read_check(idx);
    endtask

    // load a full timing set; only called with nothing in flight
    task automatic apply_timing(input logic [31:0] half, input logic [31:0] lead_mark,
                                input logic [31:0] bit_mark, input logic [31:0] lead_space,
                                input logic [31:0] rep_space, input logic [31:0] zero_sp,
                                input logic [31:0] one_sp, input logic [31:0] gap);
        reg_write(nirt_pkg::REG_CARRIER_HALF, half);
        reg_write(nirt_pkg::REG_LEADER_MARK,  lead_mark);
        reg_write(nirt_pkg::REG_BIT_MARK,     bit_mark);
        reg_write(nirt_pkg::REG_LEADER_SPACE, lead_space);
        reg_write(nirt_pkg::REG_REPEAT_SPACE, rep_space);
        reg_write(nirt_pkg::REG_ZERO_SPACE,   zero_sp);
        reg_write(nirt_pkg::REG_ONE_SPACE,    one_sp);
        reg_write(nirt_pkg::REG_FRAME_GAP,    gap);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every register must read its reset value
    task automatic test_register_defaults();
        for (int i = 0; i < 8; i++)
            reg_read_check(3'(i));
    endtask

    // ticks with nothing to send give an all-zero result
    task automatic test_idle_ticks();
        repeat (3) send_request(tick_request());
    endtask

    // extreme field values, a start while busy, a start right after the last microsecond
    task automatic test_field_extremes();
        wait_for_results();
        apply_timing(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
        send_request(start_request(8'h00, 8'hFF, 8'h00));
        // immediately rejected, all fields at their top value
        send_request(start_request(8'hFF, 8'hFF, 8'hFF));
        run_to_idle(0);
        // the tick that ended the frame left the block idle, so this one is taken
        send_request(start_request(8'hFF, 8'h00, 8'd1));
        send_request(tick_request());
        send_request(start_request(8'h00, 8'h00, 8'h00));
        run_to_idle(0);
        send_request(tick_request());
    endtask

    // registers holding zero behave as one
    task automatic test_zero_registers();
        wait_for_results();
        apply_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(start_request(8'h5A, 8'hA5, 8'd2));
        run_to_idle(0);
    endtask

    // random frames with short random timing, random content and stray requests
    task automatic test_random_frames(input int n_items, input int send_pct, input int recv_pct);
        int first;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = n_requests;
        while (n_requests - first < n_items)
        begin
            if ($urandom_range(99) < 35)
            begin
                wait_for_results();
                apply_timing($urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 2),
                             $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, 3), $urandom_range(0, 5));
            end
            else if ($urandom_range(99) < 10)
                // hold off until every result is back
                wait_for_results();
            // some idle noise between frames
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 4)) send_request(tick_request());
            send_request(start_request(8'($urandom), 8'($urandom), 8'($urandom_range(0, 5))));
            run_to_idle(3);
        end
    endtask

    // writes with bits above each register width, then space lengths changed mid-frame
    task automatic test_wide_writes_and_retiming();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_results();
        // only the low bits of each write are kept
        apply_timing(32'hFFFF_FF02, 32'hFFFF_FC01, 32'hFFFF_FC01, 32'hFFFF_0001,
                     32'hFFFF_0002, 32'hFFFF_0001, 32'hFFFF_0002, 32'hFFFF_0003);
        send_request(start_request(8'hC3, 8'h3C, 8'd1));
        run_to_idle(1);
        // longer zero space on the first bit only, then shortened mid-frame
        wait_for_results();
        apply_timing(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd6, 32'd1, 32'd1);
        send_request(start_request(8'h00, 8'h12, 8'd0));
        while (!(wave_phase == nirt_pkg::PH_BIT_MARK && wave_bits_left == 6'd31))
            send_request(tick_request());
        wait_for_results();
        reg_write(nirt_pkg::REG_ZERO_SPACE, 32'd2);
        run_to_idle(0);
        // same for a longer one space
        wait_for_results();
        reg_write(nirt_pkg::REG_ONE_SPACE, 32'd5);
        send_request(start_request(8'h01, 8'h34, 8'd0));
        while (!(wave_phase == nirt_pkg::PH_BIT_MARK && wave_bits_left == 6'd31))
            send_request(tick_request());
        wait_for_results();
        reg_write(nirt_pkg::REG_ONE_SPACE, 32'd1);
        run_to_idle(0);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        n_reg_errors = 0;
        n_requests   = 0;
        n_starts     = 0;
        n_rejects    = 0;
        n_reg_writes = 0;
        // first idling mode applies to the directed part too
        send_idle_pct = 17;
        recv_idle_pct = 47;

        // predictor and register mirror at their reset state
        timing.carrier_half = nirt_pkg::RST_CARRIER_HALF;
        timing.leader_mark  = nirt_pkg::RST_LEADER_MARK;
        timing.bit_mark     = nirt_pkg::RST_BIT_MARK;
        timing.leader_space = nirt_pkg::RST_LEADER_SPACE;
        timing.repeat_space = nirt_pkg::RST_REPEAT_SPACE;
        timing.zero_space   = nirt_pkg::RST_ZERO_SPACE;
        timing.one_space    = nirt_pkg::RST_ONE_SPACE;
        timing.frame_gap    = nirt_pkg::RST_FRAME_GAP;
        wave_phase     = nirt_pkg::PH_IDLE;
        wave_bits      = '0;
        wave_bits_left = '0;
        wave_repeats   = '0;
        wave_space     = '0;
        wave_periods   = '0;
        wave_half      = '0;
        wave_level     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_defaults();
        test_idle_ticks();
        test_field_extremes();
        test_zero_registers();
        // sender idles lightly, receiver heavily; then swapped; then no idling
        test_random_frames(150, 17, 47);
        test_random_frames(150, 47, 17);
        test_random_frames(150, 0, 0);
        test_wide_writes_and_retiming();

        // let the last results drain and give the pipeline time to settle
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("run covered %0d requests: %0d frames started, %0d starts rejected while busy",
                 n_requests, n_starts, n_rejects);
        $display("%0d results checked, %0d register writes, %0d mismatches in %0d cycles",
                 n_results, n_reg_writes, n_errors + n_reg_errors, cycle_count);
        if (n_errors == 0 && n_reg_errors == 0 && expected_levels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: nec_ir_transmitter_top.f
rtl/nirt_pkg.sv
rtl/nirt_front.sv
rtl/nirt_back.sv
rtl/nec_ir_transmitter_top.sv
dv/nec_ir_transmitter_top_tb.sv
